>>> design/rcs_pkg.sv
// rcs_pkg: shared types, codes and constants for the channel sequencer.
// No dependencies.
package rcs_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int CFG_ADDR_W = 5;

	localparam logic [23:0] TIMEOUT_RST = 24'd10000;
	localparam logic [15:0] IMIN_RST = 16'd50;
	localparam logic [15:0] IMAX_RST = 16'd1000;
	localparam logic [15:0] RDLY_RST = 16'd500;
	localparam logic [15:0] RLEN_RST = 16'd5000;

	typedef enum logic [2:0] {
		REG_TIMEOUT = 3'd0,
		REG_IMIN = 3'd1,
		REG_IMAX = 3'd2,
		REG_RDLY = 3'd3,
		REG_RLEN = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		CMD_TICK = 2'd0,
		CMD_RX = 2'd1,
		CMD_QUEUE = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_NOTHING = 3'd0,
		ST_SENT = 3'd1,
		ST_ACCEPTED = 3'd2,
		ST_OOO = 3'd3,
		ST_TIMEOUT = 3'd4,
		ST_PROTO = 3'd5,
		ST_QFULL = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_EXEC,
		FSM_DIV,
		FSM_SEND,
		FSM_OUT
	} fsm_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture input beat
		logic exec;      // run first phase of command
		logic div_start;
		logic send;      // marks the send state after the divider; the datapath leaves it unused
		logic out_load;  // result goes to output register
	} rcs_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic need_div;
		logic div_done;
	} rcs_stat_t;

endpackage

>>> design/rcs_div.sv
// rcs_div: restoring divider, one quotient bit per cycle.
// Does not use rcs_pkg; no dependencies.
module rcs_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [15:0] divisor,
	output logic [31:0] quotient,
	output logic        done
);
	logic [31:0] quo_q;
	logic [16:0] rem_q;
	logic [15:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [16:0] trial;
	logic [16:0] shifted;

	assign shifted = {rem_q[15:0], quo_q[31]};
	assign trial = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[16]) begin
				rem_q <= trial;
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
endmodule

>>> design/rcs_ctrl.sv
// rcs_ctrl: controller state machine for the sequencer.
// Depends on rcs_pkg.
module rcs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_beat,
	input  logic             out_busy,
	input  rcs_pkg::rcs_stat_t stat,
	output logic             in_rdy,
	output rcs_pkg::rcs_cmd_t  cmd
);
	import rcs_pkg::*;
	fsm_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= FSM_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FSM_IDLE: if (in_beat) state_d = FSM_EXEC;
			FSM_EXEC: state_d = stat.need_div ? FSM_DIV : FSM_OUT;
			FSM_DIV:  if (stat.div_done) state_d = FSM_SEND;
			FSM_SEND: state_d = FSM_OUT;
			FSM_OUT:  if (!out_busy) state_d = FSM_IDLE;
			default:  state_d = FSM_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_rdy = 1'b0;
		unique case (state_q)
			FSM_IDLE: begin
				in_rdy = 1'b1;
				cmd.load = in_beat;
			end
			FSM_EXEC: begin
				cmd.exec = 1'b1;
				cmd.div_start = stat.need_div;
			end
			FSM_SEND: cmd.send = 1'b1;
			FSM_OUT:  cmd.out_load = !out_busy;
			default: ;
		endcase
	end
endmodule

>>> design/rcs_dp.sv
// rcs_dp: channel state, config registers and result assembly.
// Depends on rcs_pkg and rcs_div.
module rcs_dp #(
	parameter int QUEUE_DEPTH = rcs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rcs_pkg::rcs_cmd_t  cmd,
	output rcs_pkg::rcs_stat_t stat,
	input  logic [71:0]        in_data,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_idx,
	input  logic [31:0]        cfg_wdata,
	output logic [31:0]        cfg_rdata,
	output logic [111:0]       res
);
	import rcs_pkg::*;

	logic [23:0] tmo_q;
	logic [15:0] imin_q, imax_q, rdly_q, rlen_q;
	logic [31:0] now_q, lrx_q, awake_q, ltx_q, oseq_q, iseq_q, pack_q;
	logic orel_q, irel_q, rack_q, dead_q;
	logic [4:0] pend_q;
	logic [71:0] in_q;
	logic [111:0] res_q;
	logic [31:0] intv_q;

	// captured input fields
	logic [1:0] c_cmd;
	logic [31:0] c_seq, c_ack;
	logic c_rseq, c_rack, c_rdata;
	assign c_cmd = in_q[1:0];
	assign c_seq = in_q[33:2];
	assign c_ack = in_q[65:34];
	assign c_rseq = in_q[66];
	assign c_rack = in_q[67];
	assign c_rdata = in_q[68];

	// tick phase, combinational on current state
	logic [31:0] now_n, el, rr;
	logic [4:0] qmax;
	logic orel_n, awake_upd, tick_tmo;
	assign qmax = 5'(QUEUE_DEPTH);
	assign now_n = now_q + 32'd1;
	assign tick_tmo = (now_n - lrx_q) >= {8'd0, tmo_q};
	assign orel_n = (pend_q != 5'd0 && orel_q == rack_q) ? ~orel_q : orel_q;
	assign awake_upd = orel_n != rack_q;
	assign el = now_n - (awake_upd ? now_n : awake_q);
	assign rr = el - {16'd0, rdly_q};

	logic ramp_mid;
	assign ramp_mid = (el > {16'd0, rdly_q}) && rlen_q != 16'd0 && rr < {16'd0, rlen_q};

	// ramp product |max-min| * r; r < 65536 here so 16x16
	logic [15:0] dmag;
	logic dneg;
	logic [31:0] prod;
	assign dneg = imax_q < imin_q;
	assign dmag = dneg ? imin_q - imax_q : imax_q - imin_q;
	assign prod = dmag * rr[15:0];

	logic [31:0] quo;
	logic div_done;
	rcs_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(prod), .divisor(rlen_q), .quotient(quo), .done(div_done)
	);

	assign stat.need_div = !dead_q && c_cmd == CMD_TICK && !tick_tmo && ramp_mid;
	assign stat.div_done = div_done;

	logic [31:0] intv_fast, intv_ramp;
	assign intv_fast = (el <= {16'd0, rdly_q}) ? {16'd0, imin_q} : {16'd0, imax_q};
	assign intv_ramp = dneg ? {16'd0, imin_q} - quo : {16'd0, imin_q} + quo;

	always_comb begin
		unique case (cfg_idx)
			REG_TIMEOUT: cfg_rdata = {8'd0, tmo_q};
			REG_IMIN: cfg_rdata = {16'd0, imin_q};
			REG_IMAX: cfg_rdata = {16'd0, imax_q};
			REG_RDLY: cfg_rdata = {16'd0, rdly_q};
			REG_RLEN: cfg_rdata = {16'd0, rlen_q};
			default: cfg_rdata = '0;
		endcase
	end

	// pending tick send check: flagged in exec, evaluated when the result is loaded
	logic tick_pend_q;
	logic send_now;
	logic send_chk;
	logic [31:0] oseq_n;
	assign send_chk = (now_q - ltx_q) >= intv_q;
	assign send_now = tick_pend_q && cmd.out_load && send_chk;
	assign oseq_n = (oseq_q != 32'hFFFF_FFFF) ? oseq_q + 32'd1 : oseq_q;

	// result layout: status, tx_seq, tx_ack, rel_seq, rel_ack, rel_data, lost, rrx, rdel, qlvl
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tmo_q <= TIMEOUT_RST; imin_q <= IMIN_RST; imax_q <= IMAX_RST;
			rdly_q <= RDLY_RST; rlen_q <= RLEN_RST;
			now_q <= '0; lrx_q <= '0; awake_q <= '0; ltx_q <= '0;
			oseq_q <= '0; iseq_q <= '0; pack_q <= '0;
			orel_q <= 1'b0; irel_q <= 1'b0; rack_q <= 1'b0; dead_q <= 1'b0;
			pend_q <= '0;
			res_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_TIMEOUT: tmo_q <= cfg_wdata[23:0];
					REG_IMIN: imin_q <= cfg_wdata[15:0];
					REG_IMAX: imax_q <= cfg_wdata[15:0];
					REG_RDLY: rdly_q <= cfg_wdata[15:0];
					REG_RLEN: rlen_q <= cfg_wdata[15:0];
					default: ;
				endcase
			end
			if (cmd.exec) begin
				res_q <= '0;
				if (!dead_q) begin
					unique case (c_cmd)
						CMD_TICK: begin
							now_q <= now_n;
							if (tick_tmo) begin
								dead_q <= 1'b1;
								res_q[2:0] <= ST_TIMEOUT;
							end else begin
								orel_q <= orel_n;
								if (awake_upd) awake_q <= now_n;
							end
						end
						CMD_RX: begin
							if (c_seq <= iseq_q) res_q[2:0] <= ST_OOO;
							else begin
								res_q[101:70] <= c_seq - iseq_q - 32'd1;
								if (c_rdata) awake_q <= now_q;
								iseq_q <= c_seq;
								pack_q <= c_ack;
								if (c_rseq != irel_q && !c_rdata) begin
									dead_q <= 1'b1;
									res_q[2:0] <= ST_PROTO;
								end else begin
									if (c_rseq != irel_q) begin
										res_q[102] <= 1'b1;
										irel_q <= c_rseq;
									end
									if (c_rack != rack_q) begin
										res_q[103] <= 1'b1;
										if (pend_q != 5'd0) pend_q <= pend_q - 5'd1;
										rack_q <= c_rack;
									end
									lrx_q <= now_q;
									res_q[2:0] <= ST_ACCEPTED;
								end
							end
						end
						CMD_QUEUE: begin
							if (pend_q >= qmax) res_q[2:0] <= ST_QFULL;
							else pend_q <= pend_q + 5'd1;
						end
						default: ;
					endcase
				end
			end
			if (send_now) begin
				ltx_q <= now_q;
				oseq_q <= oseq_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tick_pend_q <= 1'b0;
		else if (cmd.exec) tick_pend_q <= !dead_q && c_cmd == CMD_TICK && !tick_tmo;
		else if (cmd.out_load) tick_pend_q <= 1'b0;
	end

	// interval set at exec from pre-update state (el uses now_n), or from the divider on a ramp
	logic [31:0] intv_exec;
	assign intv_exec = ramp_mid ? 32'd0 : intv_fast;
	always_ff @(posedge clk) begin
		if (cmd.exec) intv_q <= intv_exec;
		else if (div_done) intv_q <= intv_ramp;
		if (cmd.load) in_q <= in_data;
	end

	always_comb begin
		res = res_q;
		if (send_now) begin
			res[2:0] = ST_SENT;
			res[34:3] = oseq_n;
			res[66:35] = iseq_q;
			res[67] = orel_q;
			res[68] = irel_q;
			res[69] = orel_q != rack_q && pend_q != 5'd0;
		end
		res[108:104] = pend_q;
		res[111:109] = '0;
	end

	logic unused;
	assign unused = ^{pack_q, in_q[71:69], cmd.send};
endmodule

>>> design/reliable_channel_sequencer_core.sv
// Top level: channel sequencer, one command per input beat, one result beat each.
// Each result passes the exec and output states; a tick whose interval ramps also waits
// in the divide and send states for the serial divider. A new input beat is taken only
// after the last result is loaded; a stalled result holds the block in its output
// state. Reset (arst_n low) clears the control and channel state and loads the
// register defaults.
module reliable_channel_sequencer_core #(
	parameter int QUEUE_DEPTH = rcs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [1:0]                  s_tuser, // cmd
	input  logic [71:0]                 s_tdata, // pkt_seq, pkt_ack, pkt_rel_seq,
	                                             // pkt_rel_ack, pkt reliable-data flag
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [2:0]                  m_tuser, // status
	output logic [111:0]                m_tdata, // tx_seq, tx_ack, tx_rel_seq, tx_rel_ack,
	                                             // tx reliable-data flag, lost_count,
	                                             // reliable_received, reliable_delivered,
	                                             // queue_level
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rcs_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import rcs_pkg::*;
	rcs_cmd_t cmd;
	rcs_stat_t stat;
	logic [111:0] res;
	logic out_busy;

	assign pready = 1'b1;
	assign out_busy = m_tvalid && !m_tready;

	rcs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_beat(s_tvalid && s_tready),
		.out_busy(out_busy), .stat(stat), .in_rdy(s_tready), .cmd(cmd)
	);

	rcs_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.in_data({3'd0, s_tdata[66:0], s_tuser}),
		.cfg_we(psel && penable && pwrite), .cfg_idx(paddr[4:2]),
		.cfg_wdata(pwdata), .cfg_rdata(prdata), .res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid <= 1'b0;
		else if (cmd.out_load) m_tvalid <= 1'b1;
		else if (m_tready) m_tvalid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_tuser <= res[2:0];
			m_tdata <= {6'd0, res[108:3]};
		end
	end
endmodule

>>> design/rcs_chk.sv
// rcs_chk: port-level checks for the sequencer, bound to the top level.
// Depends on rcs_pkg.
module rcs_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [2:0]   m_tuser,
	input logic [111:0] m_tdata
);
	import rcs_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable({m_tuser, m_tdata}))
		else $error("result beat dropped");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser <= ST_QFULL)
		else $error("bad status");

	a_qlvl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[105:101] <= 5'(QUEUE_DEPTH_DEF))
		else $error("queue level range");

	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while busy");
endmodule

bind reliable_channel_sequencer_core rcs_chk u_chk (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata)
);

>>> tb/tb_top.sv
// Testbench for reliable_channel_sequencer_core: streams ticks, received headers and
// queue commands, predicts every result beat in a scoreboard class and checks it.
// Depends on rcs_pkg and the core RTL only.
`timescale 1ns / 100ps

import rcs_pkg::*;

typedef struct packed {
	logic [2:0]  pad;
	logic        data_flag;
	logic        rel_ack;
	logic        rel_seq;
	logic [31:0] ack;
	logic [31:0] seq;
	cmd_t        cmd;
} hdr_beat_t;

typedef struct packed {
	logic [2:0]  pad;
	logic [4:0]  queue_level;
	logic        rel_delivered;
	logic        rel_received;
	logic [31:0] lost_count;
	logic        tx_carry;
	logic        tx_rel_ack;
	logic        tx_rel_seq;
	logic [31:0] tx_ack;
	logic [31:0] tx_seq;
	status_t     status;
} chan_beat_t;

class channel_scoreboard;
	logic [23:0] timeout_ticks = TIMEOUT_RST;
	logic [15:0] imin = IMIN_RST, imax = IMAX_RST, rdly = RDLY_RST, rlen = RLEN_RST;
	logic [31:0] now_ticks, last_rx, awake, last_tx, out_seq, in_seq_latest, peer_ack;
	logic        out_rel, in_rel, rel_ack, dead;
	int unsigned pending;
	int          errors;
	int unsigned checked;
	chan_beat_t  exp_ring[16];
	logic [3:0]  ring_wr, ring_rd;
	int unsigned in_flight;

	function new();
		now_ticks = 0; last_rx = 0; awake = 0; last_tx = 0; out_seq = 0;
		in_seq_latest = 0; peer_ack = 0; out_rel = 0; in_rel = 0; rel_ack = 0;
		dead = 0; pending = 0; errors = 0; checked = 0;
		ring_wr = '0; ring_rd = '0; in_flight = 0;
	endfunction

	function void set_reg(reg_idx_t idx, logic [31:0] v);
		case (idx)
			REG_TIMEOUT: timeout_ticks = v[23:0];
			REG_IMIN: imin = v[15:0];
			REG_IMAX: imax = v[15:0];
			REG_RDLY: rdly = v[15:0];
			REG_RLEN: rlen = v[15:0];
			default: ;
		endcase
	endfunction

	function logic [31:0] send_interval();
		logic [31:0] el, r;
		longint diff, val;
		el = now_ticks - awake;
		if (el <= {16'd0, rdly}) return {16'd0, imin};
		r = el - {16'd0, rdly};
		if (rlen == 0 || r >= {16'd0, rlen}) return {16'd0, imax};
		diff = longint'(imax) - longint'(imin);
		val = longint'(imin) + (diff * longint'(r)) / longint'(rlen);
		return val[31:0];
	endfunction

	// predict the result of one accepted beat
	function void note_input(hdr_beat_t b);
		chan_beat_t r;
		r = '0;
		r.status = ST_NOTHING;
		if (!dead) begin
			case (b.cmd)
				CMD_TICK: begin
					now_ticks = now_ticks + 1;
					if (now_ticks - last_rx >= {8'd0, timeout_ticks}) begin
						dead = 1;
						r.status = ST_TIMEOUT;
					end else begin
						if (pending > 0 && out_rel == rel_ack) out_rel = ~out_rel;
						if (out_rel != rel_ack) awake = now_ticks;
						if (now_ticks - last_tx >= send_interval()) begin
							last_tx = now_ticks;
							if (out_seq != 32'hFFFF_FFFF) out_seq = out_seq + 1;
							r.status = ST_SENT;
							r.tx_seq = out_seq;
							r.tx_ack = in_seq_latest;
							r.tx_rel_seq = out_rel;
							r.tx_rel_ack = in_rel;
							r.tx_carry = (out_rel != rel_ack) && pending > 0;
						end
					end
				end
				CMD_RX: begin
					if (b.seq <= in_seq_latest) begin
						r.status = ST_OOO;
					end else begin
						r.lost_count = b.seq - in_seq_latest - 1;
						if (b.data_flag) awake = now_ticks;
						in_seq_latest = b.seq;
						peer_ack = b.ack;
						if (b.rel_seq != in_rel && !b.data_flag) begin
							dead = 1;
							r.status = ST_PROTO;
						end else begin
							if (b.rel_seq != in_rel) begin
								r.rel_received = 1;
								in_rel = b.rel_seq;
							end
							if (b.rel_ack != rel_ack) begin
								r.rel_delivered = 1;
								if (pending > 0) pending--;
								rel_ack = b.rel_ack;
							end
							last_rx = now_ticks;
							r.status = ST_ACCEPTED;
						end
					end
				end
				CMD_QUEUE: begin
					if (pending >= QUEUE_DEPTH_DEF) r.status = ST_QFULL;
					else pending++;
				end
				default: ;
			endcase
		end
		r.queue_level = pending[4:0];
		exp_ring[ring_wr] = r;
		ring_wr++;
		in_flight++;
	endfunction

	function void cmp(string f, logic [31:0] e, logic [31:0] a);
		if (e !== a) begin
			$error("%s: expected %0h, got %0h", f, e, a);
			errors++;
		end
	endfunction

	function void check_result(logic [2:0] u, logic [111:0] d);
		chan_beat_t a, e;
		a = chan_beat_t'({3'd0, d[105:0], u});
		if (in_flight == 0) begin
			$error("result beat with nothing expected: %h %h", u, d);
			errors++;
			return;
		end
		e = exp_ring[ring_rd];
		ring_rd++;
		in_flight--;
		checked++;
		cmp("status", 32'(e.status), 32'(a.status));
		cmp("tx_seq", e.tx_seq, a.tx_seq);
		cmp("tx_ack", e.tx_ack, a.tx_ack);
		cmp("tx_rel_seq", 32'(e.tx_rel_seq), 32'(a.tx_rel_seq));
		cmp("tx_rel_ack", 32'(e.tx_rel_ack), 32'(a.tx_rel_ack));
		cmp("tx reliable-data flag", 32'(e.tx_carry), 32'(a.tx_carry));
		cmp("lost_count", e.lost_count, a.lost_count);
		cmp("reliable_received", 32'(e.rel_received), 32'(a.rel_received));
		cmp("reliable_delivered", 32'(e.rel_delivered), 32'(a.rel_delivered));
		cmp("queue_level", 32'(e.queue_level), 32'(a.queue_level));
	endfunction
endclass

module tb_top;
	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_tvalid = 0;
	logic         s_tready;
	logic [1:0]   s_tuser = '0;  // cmd
	logic [71:0]  s_tdata = '0;  // pkt_seq, pkt_ack, pkt_rel_seq, pkt_rel_ack, data flag
	logic         m_tvalid;
	logic         m_tready = 0;
	logic [2:0]   m_tuser;       // status
	logic [111:0] m_tdata;       // tx_seq, tx_ack, tx_rel_seq, tx_rel_ack, data flag,
	                             // lost_count, reliable_received, reliable_delivered,
	                             // queue_level
	logic         psel = 0, penable = 0, pwrite = 0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;

	channel_scoreboard chan_sb = new();
	int unsigned sent_beats = 0;
	int unsigned burst_left = 0;
	int unsigned idle_cycles = 0;
	int unsigned stall_mode = 0;
	int unsigned stall_cnt = 0;

	localparam int unsigned WATCHDOG_LIMIT = 20000;

	reliable_channel_sequencer_core dut (.*);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	// receiver backpressure: the mode is redrawn at random from four modes
	always @(posedge clk) begin
		stall_cnt <= stall_cnt + 1;
		if (stall_cnt % 64 == 0) stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 9) < 7);
			2: m_tready <= (stall_cnt % 8) < 2;
			default: m_tready <= ($urandom_range(0, 9) < 2);
		endcase
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) chan_sb.check_result(m_tuser, m_tdata);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
			$display("reliable_channel_sequencer_core regression: fail");
			$finish;
		end
	end

	task automatic send_beat(hdr_beat_t b);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tuser <= b.cmd;
		s_tdata <= {5'd0, b.data_flag, b.rel_ack, b.rel_seq, b.ack, b.seq};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		chan_sb.note_input(b);
		sent_beats++;
	endtask

	task automatic drain();
		if (s_tvalid) s_tvalid <= 1'b0;
		burst_left = 0;
		while (chan_sb.in_flight != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic cfg_write(reg_idx_t idx, logic [31:0] v);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= CFG_ADDR_W'(idx) << 2; pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		chan_sb.set_reg(idx, v);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_phase(logic [31:0] tmo, imn, imx, dly, len);
		drain();
		cfg_write(REG_TIMEOUT, tmo);
		cfg_write(REG_IMIN, imn);
		cfg_write(REG_IMAX, imx);
		cfg_write(REG_RDLY, dly);
		cfg_write(REG_RLEN, len);
	endtask

	function automatic hdr_beat_t mk(cmd_t c, logic [31:0] seq, logic [31:0] ack,
			logic rs, logic ra, logic rd);
		hdr_beat_t b;
		b = '0;
		b.cmd = c; b.seq = seq; b.ack = ack;
		b.rel_seq = rs; b.rel_ack = ra; b.data_flag = rd;
		return b;
	endfunction

	// well-formed receive: sequence moves forward, reliable bit only changes with data
	function automatic hdr_beat_t good_rx();
		logic [31:0] inc;
		logic rd;
		inc = ($urandom_range(0, 9) == 0 && chan_sb.in_seq_latest < 32'hE000_0000)
			? $urandom_range(1, 32'h0100_0000) : $urandom_range(1, 3);
		rd = 1'($urandom_range(0, 1));
		return mk(CMD_RX, chan_sb.in_seq_latest + inc, $urandom(),
			rd ? 1'($urandom_range(0, 1)) : chan_sb.in_rel,
			1'($urandom_range(0, 1)), rd);
	endfunction

	function automatic hdr_beat_t rand_beat();
		int unsigned p;
		hdr_beat_t b;
		p = $urandom_range(0, 99);
		b = mk(CMD_TICK, $urandom(), $urandom(), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		if (p < 55) return b;  // ticks carry junk fields the block must ignore
		if (p < 80) return good_rx();
		if (p < 90) begin
			b.cmd = CMD_QUEUE;
			return b;
		end
		if (p < 96) begin
			b.cmd = CMD_RX;
			b.seq = $urandom_range(0, chan_sb.in_seq_latest);
			return b;
		end
		b.cmd = CMD_NONE;
		return b;
	endfunction

	task automatic random_run(int unsigned n);
		repeat (n) send_beat(rand_beat());
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: defaults, queue fill, delivery, out of order, gaps, unknown cmd
		send_beat(mk(CMD_RX, 32'd1, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0)); // delivery, empty queue
		send_beat(mk(CMD_QUEUE, '0, '0, 1'b0, 1'b0, 1'b0));
		send_beat(mk(CMD_TICK, '0, '0, 1'b0, 1'b0, 1'b0));
		send_beat(mk(CMD_RX, 32'd1, 32'd0, 1'b0, 1'b1, 1'b0));        // duplicate
		send_beat(mk(CMD_RX, 32'd0, 32'd0, 1'b0, 1'b1, 1'b0));
		send_beat(mk(CMD_RX, 32'd5, 32'h1234_5678, 1'b1, 1'b0, 1'b1)); // lost 3, new data
		send_beat(mk(CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1));
		repeat (17) send_beat(mk(CMD_QUEUE, '0, '0, 1'b0, 1'b0, 1'b0)); // last one is full
		send_beat(mk(CMD_TICK, '0, '0, 1'b0, 1'b0, 1'b0));
		random_run(220);

		set_phase(32'hFF_FFFF, 32'd0, 32'hFFFF, 32'd0, 32'hFFFF);
		random_run(230);
		set_phase(32'h10_0000, 32'd10, 32'd2, 32'd3, 32'd40);          // max below min
		random_run(230);
		set_phase(32'h10_0000, 32'd1, 32'd30, 32'd0, 32'd0);           // zero ramp length
		random_run(230);
		set_phase(32'hFF_FFFF, 32'd3, 32'd0, 32'hFFFF, 32'd7);
		random_run(120);
		set_phase(32'h80_0000, $urandom_range(0, 20), $urandom_range(0, 60),
			$urandom_range(0, 8), $urandom_range(1, 100));
		random_run(120);

		// top of sequence space, then a protocol error kills the channel for good
		send_beat(mk(CMD_RX, 32'hFFFF_FFFE, 32'h0, chan_sb.in_rel, 1'b0, 1'b0));
		send_beat(mk(CMD_RX, 32'hFFFF_FFFF, 32'hFFFF_FFFF, ~chan_sb.in_rel, 1'b0, 1'b0));
		send_beat(mk(CMD_TICK, '0, '0, 1'b0, 1'b0, 1'b0));
		send_beat(mk(CMD_QUEUE, '0, '0, 1'b0, 1'b0, 1'b0));
		send_beat(mk(CMD_RX, 32'hFFFF_FFFF, '0, 1'b0, 1'b1, 1'b1));
		set_phase(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);                  // zero timeout
		send_beat(mk(CMD_TICK, '0, '0, 1'b0, 1'b0, 1'b0));
		drain();

		$display("covered %0d input beats, %0d result beats checked, over 7 register settings",
			sent_beats, chan_sb.checked);
		if (chan_sb.errors == 0) begin
			$display("reliable_channel_sequencer_core regression: pass");
		end else begin
			$display("reliable_channel_sequencer_core regression: fail");
		end
		$finish;
	end
endmodule

>>> reliable_channel_sequencer_core.f
design/rcs_pkg.sv
design/rcs_div.sv
design/rcs_ctrl.sv
design/rcs_dp.sv
design/reliable_channel_sequencer_core.sv
design/rcs_chk.sv
tb/tb_top.sv
